@@ rtl/core/png_cd_pkg.sv @@
// Shared types, constants and the chunk type lookup for the PNG chunk deframer.
package png_cd_pkg;

    // Byte regions, as reported on the result channel
    localparam logic [2:0] REGION_SIG     = 3'd0;
    localparam logic [2:0] REGION_LEN     = 3'd1;
    localparam logic [2:0] REGION_TYPE    = 3'd2;
    localparam logic [2:0] REGION_DATA    = 3'd3;
    localparam logic [2:0] REGION_CRC     = 3'd4;
    localparam logic [2:0] REGION_IGNORED = 3'd5;

    // Sticky status codes
    localparam logic [2:0] STATUS_OK       = 3'd0;
    localparam logic [2:0] STATUS_BADSIG   = 3'd1;
    localparam logic [2:0] STATUS_OVERFLOW = 3'd2;
    localparam logic [2:0] STATUS_ZERO     = 3'd3;
    localparam logic [2:0] STATUS_DONE     = 3'd4;

    localparam logic [3:0]  UNKNOWN_TYPE   = 4'd13;
    localparam logic [3:0]  IEND_INDEX     = 4'd3;
    localparam logic [15:0] MAX_LEN_RESET  = 16'hFFFF;
    localparam int          TYPE_TABLE_SIZE = 13;
    localparam int          TYPE_COUNT_DEF  = 13;

    // Result queue depth, power of two
    localparam int          FIFO_DEPTH = 2;

    localparam logic [7:0] SIG_BYTES [8] = '{
        8'h89, 8'h50, 8'h4e, 8'h47, 8'h0d, 8'h0a, 8'h1a, 8'h0a
    };

    // IHDR PLTE IDAT IEND tRNS cHRM gAMA iCCP sBIT sRGB cICP mDCV cLLI
    localparam logic [31:0] TYPE_CODES [TYPE_TABLE_SIZE] = '{
        32'h49484452, 32'h504c5445, 32'h49444154, 32'h49454e44,
        32'h74524e53, 32'h6348524d, 32'h67414d41, 32'h69434350,
        32'h73424954, 32'h73524742, 32'h63494350, 32'h6d444356,
        32'h634c4c49
    };

    // One classified byte
    typedef struct packed {
        logic [2:0]  region;
        logic [3:0]  type_index;
        logic [15:0] cur_len;
        logic        chunk_last;
        logic [2:0]  status;
    } png_cd_rec_t;

    // Parallel compare of a type word against the first count table entries
    function automatic logic [3:0] type_lookup(input logic [31:0] code, input int count);
        logic [3:0] found;
        found = UNKNOWN_TYPE;
        for (int i = 0; i < TYPE_TABLE_SIZE; i++) begin
            if (i < count && TYPE_CODES[i] == code) begin
                found = 4'(i);
            end
        end
        return found;
    endfunction

endpackage

@@ rtl/core/png_cd_front.sv @@
// Front end: byte classifier and chunk walker state machine.
module png_cd_front #(
    parameter int TYPE_COUNT = png_cd_pkg::TYPE_COUNT_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [15:0]              cfg_wr_data,
    input  logic                     byte_valid,
    input  logic [7:0]               in_byte,
    output png_cd_pkg::png_cd_rec_t  rec
);
    import png_cd_pkg::*;

    localparam logic [2:0] PH_SIG  = 3'd0;
    localparam logic [2:0] PH_LEN  = 3'd1;
    localparam logic [2:0] PH_TYPE = 3'd2;
    localparam logic [2:0] PH_DATA = 3'd3;
    localparam logic [2:0] PH_CRC  = 3'd4;
    localparam logic [2:0] PH_HALT = 3'd5;

    logic [2:0]  phase_reg, phase_next;
    logic [15:0] count_reg, count_next;
    logic [31:0] length_reg, length_next;
    logic [31:0] type_reg, type_next;
    logic [3:0]  matched_reg, matched_next;
    logic        end_seen_reg, end_seen_next;
    logic [2:0]  status_reg, status_next;
    logic [15:0] max_len_reg;

    logic [31:0] len_shift;
    logic [31:0] type_word;
    logic [3:0]  type_hit;
    logic [15:0] count_inc;
    logic [15:0] cur_len;

    assign len_shift = {length_reg[23:0], in_byte};
    assign type_word = {type_reg[23:0], in_byte};
    assign type_hit  = type_lookup(type_word, TYPE_COUNT);
    assign count_inc = count_reg + 16'd1;
    assign cur_len   = length_reg[15:0];

    always_comb begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        length_next   = length_reg;
        type_next     = type_reg;
        matched_next  = matched_reg;
        end_seen_next = end_seen_reg;
        status_next   = status_reg;

        rec.region     = REGION_IGNORED;
        rec.type_index = UNKNOWN_TYPE;
        rec.cur_len    = 16'd0;
        rec.chunk_last = 1'b0;

        unique case (phase_reg)
            PH_SIG: begin
                rec.region = REGION_SIG;
                if (in_byte != SIG_BYTES[count_reg[2:0]]) begin
                    status_next = STATUS_BADSIG;
                    phase_next  = PH_HALT;
                end else if (count_reg >= 16'd7) begin
                    phase_next   = PH_LEN;
                    count_next   = 16'd0;
                    length_next  = 32'd0;
                    type_next    = 32'd0;
                    matched_next = UNKNOWN_TYPE;
                    end_seen_next = 1'b0;
                end else begin
                    count_next = count_inc;
                end
            end
            PH_LEN: begin
                rec.region  = REGION_LEN;
                length_next = len_shift;
                if (count_reg >= 16'd3) begin
                    if (len_shift > {16'd0, max_len_reg}) begin
                        status_next = STATUS_OVERFLOW;
                        phase_next  = PH_HALT;
                    end else begin
                        phase_next = PH_TYPE;
                        count_next = 16'd0;
                    end
                end else begin
                    count_next = count_inc;
                end
            end
            PH_TYPE: begin
                rec.region  = REGION_TYPE;
                rec.cur_len = cur_len;
                type_next   = type_word;
                if (count_reg >= 16'd3) begin
                    matched_next   = type_hit;
                    rec.type_index = type_hit;
                    end_seen_next  = (type_hit == IEND_INDEX);
                    count_next     = 16'd0;
                    if (cur_len == 16'd0) begin
                        if (type_hit == IEND_INDEX) begin
                            phase_next = PH_CRC;
                        end else begin
                            status_next = STATUS_ZERO;
                            phase_next  = PH_HALT;
                        end
                    end else begin
                        phase_next = PH_DATA;
                    end
                end else begin
                    count_next = count_inc;
                end
            end
            PH_DATA: begin
                rec.region     = REGION_DATA;
                rec.cur_len    = cur_len;
                rec.type_index = matched_reg;
                if (count_inc >= cur_len) begin
                    phase_next = PH_CRC;
                    count_next = 16'd0;
                end else begin
                    count_next = count_inc;
                end
            end
            PH_CRC: begin
                rec.region     = REGION_CRC;
                rec.cur_len    = cur_len;
                rec.type_index = matched_reg;
                if (count_reg >= 16'd3) begin
                    rec.chunk_last = 1'b1;
                    if (end_seen_reg) begin
                        status_next = STATUS_DONE;
                        phase_next  = PH_HALT;
                    end else begin
                        phase_next    = PH_LEN;
                        count_next    = 16'd0;
                        length_next   = 32'd0;
                        type_next     = 32'd0;
                        matched_next  = UNKNOWN_TYPE;
                        end_seen_next = 1'b0;
                    end
                end else begin
                    count_next = count_inc;
                end
            end
            default: begin
                rec.region = REGION_IGNORED;
            end
        endcase

        rec.status = status_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_SIG;
            count_reg    <= 16'd0;
            length_reg   <= 32'd0;
            type_reg     <= 32'd0;
            matched_reg  <= UNKNOWN_TYPE;
            end_seen_reg <= 1'b0;
            status_reg   <= STATUS_OK;
        end else if (byte_valid) begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            length_reg   <= length_next;
            type_reg     <= type_next;
            matched_reg  <= matched_next;
            end_seen_reg <= end_seen_next;
            status_reg   <= status_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAX_LEN_RESET;
        end else if (cfg_wr_en) begin
            max_len_reg <= cfg_wr_data;
        end
    end

endmodule

@@ rtl/core/png_cd_fifo.sv @@
// Short queue of classified bytes between the front end and the output stage.
module png_cd_fifo (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     push,
    input  png_cd_pkg::png_cd_rec_t  push_rec,
    output logic                     full,
    input  logic                     pop,
    output logic                     empty,
    output png_cd_pkg::png_cd_rec_t  pop_rec
);
    import png_cd_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    png_cd_rec_t      slots [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full    = (count_reg == CNT_W'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_rec = slots[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

@@ rtl/core/png_cd_back.sv @@
// Back end: output register that packs queued records onto the result stream.
module png_cd_back (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     q_empty,
    input  png_cd_pkg::png_cd_rec_t  q_rec,
    output logic                     q_pop,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [23:0]              m_tdata,
    output logic [6:0]               m_tuser,
    output logic                     m_tlast
);
    import png_cd_pkg::*;

    logic        valid_reg;
    logic [23:0] data_reg;
    logic [6:0]  user_reg;
    logic        last_reg;

    assign q_pop    = !q_empty && (!valid_reg || m_tready);
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (q_pop) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            data_reg <= {5'd0, q_rec.status, q_rec.cur_len};
            user_reg <= {q_rec.type_index, q_rec.region};
            last_reg <= q_rec.chunk_last;
        end
    end

endmodule

@@ rtl/core/png_chunk_deframer.sv @@
// Top level of the PNG chunk deframer: byte walker, result queue and output stage.
//
//  channel   dir  handshake          contents
//  s_*       in   s_tvalid/s_tready  tdata[7:0] file byte
//  m_*       out  m_tvalid/m_tready  one result per byte: region, type, length, status
//  cfg_*     in   cfg_wr_en          cfg_wr_data[15:0] max chunk data length
//
// One byte per cycle sustained while m_ is not stalled; a result reaches m_ by way of
// the queue, which the walker writes at the accepting edge, and then the output register,
// which the queue loads once that register is empty or being taken.
// Synchronous active-low reset: walker to signature check, limit to 0xFFFF,
// queue and output empty.
// A stall on m_ fills the two-entry queue; s_tready drops only once it is full.
module png_chunk_deframer #(
    parameter int TYPE_COUNT = png_cd_pkg::TYPE_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] current_length, [18:16] status, [23:19] zero
    output logic [6:0]  m_tuser,   // [2:0] byte_region, [6:3] type_index
    output logic        m_tlast    // chunk_last: final CRC byte of a chunk
);
    import png_cd_pkg::*;

    png_cd_rec_t front_rec;
    png_cd_rec_t q_rec;
    logic        q_full;
    logic        q_empty;
    logic        q_pop;
    logic        byte_xfer;

    // Front end steps on every accepted transfer; the queue has room by construction.
    assign s_tready  = !q_full;
    assign byte_xfer = s_tvalid && s_tready;

    png_cd_front #(
        .TYPE_COUNT (TYPE_COUNT)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .byte_valid  (byte_xfer),
        .in_byte     (s_tdata),
        .rec         (front_rec)
    );

    // Decouples the walker from output backpressure.
    png_cd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (byte_xfer),
        .push_rec (front_rec),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .pop_rec  (q_rec)
    );

    png_cd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_rec    (q_rec),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
